>>> sv/msbc_pkg.sv
`default_nettype none

package msbc_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int COEF_BITS       = 32;
    localparam int COEF_FRAC_BITS  = 30;
    localparam int STATE_FRAC_BITS = 8;
    localparam int FB_BITS         = 40;
    localparam int ACC_BITS        = 64;
    localparam int YL_BITS         = 24;
    localparam int YH_BITS         = FB_BITS - YL_BITS;
    localparam int NUM_REGS        = 8;
    localparam int REG_IDX_BITS    = $clog2(NUM_REGS);
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_HP_GAIN_ZERO = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_HP_GAIN_ONE  = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_HP_FB_ONE    = REG_IDX_BITS'(2);
    localparam logic [REG_IDX_BITS-1:0] REG_HP_FB_TWO    = REG_IDX_BITS'(3);
    localparam logic [REG_IDX_BITS-1:0] REG_LP_GAIN_ZERO = REG_IDX_BITS'(4);
    localparam logic [REG_IDX_BITS-1:0] REG_LP_GAIN_ONE  = REG_IDX_BITS'(5);
    localparam logic [REG_IDX_BITS-1:0] REG_LP_FB_ONE    = REG_IDX_BITS'(6);
    localparam logic [REG_IDX_BITS-1:0] REG_LP_FB_TWO    = REG_IDX_BITS'(7);

    // coefficient defaults, Q2.30
    localparam logic signed [COEF_BITS-1:0] RST_HP_GAIN_ZERO = 32'sd1024720945;
    localparam logic signed [COEF_BITS-1:0] RST_HP_GAIN_ONE  = -32'sd2049441890;
    localparam logic signed [COEF_BITS-1:0] RST_HP_FB_ONE    = -32'sd2047245532;
    localparam logic signed [COEF_BITS-1:0] RST_HP_FB_TWO    = 32'sd977896423;
    localparam logic signed [COEF_BITS-1:0] RST_LP_GAIN_ZERO = 32'sd1098179;
    localparam logic signed [COEF_BITS-1:0] RST_LP_GAIN_ONE  = 32'sd2196357;
    localparam logic signed [COEF_BITS-1:0] RST_LP_FB_ONE    = -32'sd2047245532;
    localparam logic signed [COEF_BITS-1:0] RST_LP_FB_TWO    = 32'sd977896423;

    localparam logic signed [ACC_BITS-1:0] Y_MAX =
        ACC_BITS'((64'sd1 <<< (FB_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - ACC_BITS'(1);
    localparam logic signed [FB_BITS-1:0] O_MAX =
        FB_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [FB_BITS-1:0] O_MIN = -O_MAX - FB_BITS'(1);
    localparam logic [FB_BITS-1:0] FRAC_MASK =
        FB_BITS'((64'd1 << STATE_FRAC_BITS) - 64'd1);

    typedef struct packed {
        logic signed [COEF_BITS-1:0] g0;
        logic signed [COEF_BITS-1:0] g1;
        logic signed [COEF_BITS-1:0] f1;
        logic signed [COEF_BITS-1:0] f2;
    } band_coef_t;

    typedef struct packed {
        band_coef_t hp;
        band_coef_t lp;
    } coef_t;

    // feedforward sums for one item, both bands
    typedef struct packed {
        logic signed [ACC_BITS-1:0] hp;
        logic signed [ACC_BITS-1:0] lp;
    } ff_item_t;

    // g0*(x + x2) + g1*x1, scaled by the state fraction
    function automatic logic signed [ACC_BITS-1:0] ff_calc(
        band_coef_t c,
        logic signed [SAMPLE_BITS-1:0] x,
        logic signed [SAMPLE_BITS-1:0] x1,
        logic signed [SAMPLE_BITS-1:0] x2
    );
        logic signed [SAMPLE_BITS:0]             xs;
        logic signed [COEF_BITS+SAMPLE_BITS:0]   p0;
        logic signed [COEF_BITS+SAMPLE_BITS-1:0] p1;
        logic signed [ACC_BITS-1:0]              s;
        xs = (SAMPLE_BITS + 1)'(x) + (SAMPLE_BITS + 1)'(x2);
        p0 = c.g0 * xs;
        p1 = c.g1 * x1;
        s  = ACC_BITS'(p0) + ACC_BITS'(p1);
        return s <<< STATE_FRAC_BITS;
    endfunction

    // coefficient times the unsigned low slice of a state word
    function automatic logic signed [ACC_BITS-1:0] fb_low(
        logic signed [COEF_BITS-1:0] f,
        logic signed [FB_BITS-1:0]   y
    );
        logic signed [YL_BITS:0]           yl;
        logic signed [COEF_BITS+YL_BITS:0] pl;
        yl = {1'b0, y[YL_BITS-1:0]};
        pl = f * yl;
        return ACC_BITS'(pl);
    endfunction

    // coefficient times the signed high slice, weighted back into place
    function automatic logic signed [ACC_BITS-1:0] fb_high(
        logic signed [COEF_BITS-1:0] f,
        logic signed [FB_BITS-1:0]   y
    );
        logic signed [YH_BITS-1:0]           yh;
        logic signed [COEF_BITS+YH_BITS-1:0] ph;
        yh = y[FB_BITS-1:YL_BITS];
        ph = f * yh;
        return ACC_BITS'(ph) <<< YL_BITS;
    endfunction

    // new feedback state: floor shift, clamp to state width
    function automatic logic signed [FB_BITS-1:0] y_calc(logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS-1:0] t;
        t = acc >>> COEF_FRAC_BITS;
        if (t > Y_MAX)
            t = Y_MAX;
        else if (t < Y_MIN)
            t = Y_MIN;
        return t[FB_BITS-1:0];
    endfunction

    // drop fraction toward zero, clamp to sample width
    function automatic logic signed [SAMPLE_BITS-1:0] out_fmt(logic signed [FB_BITS-1:0] y);
        logic signed [FB_BITS-1:0] q;
        q = y >>> STATE_FRAC_BITS;
        if (y[FB_BITS-1] && ((y & FRAC_MASK) != '0))
            q = q + FB_BITS'(1);
        if (q > O_MAX)
            q = O_MAX;
        else if (q < O_MIN)
            q = O_MIN;
        return q[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/mono_sum_biquad_crossover_unit.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   left_sample, right_sample (signed 24)
// output    out_valid / out_ready high_band, low_band (signed 24)
// config    cfg_we (no wait)      cfg_index (3), cfg_data (32)
//
// The back end takes a new item only once the last one completes, held back
// by the feedback loop: the 40-bit y[n-1] times b1 is split into a low and a
// high partial product, formed in turn. Front stage and queue keep taking
// items meanwhile.
// Reset clears filter history and handshake state at once and loads the
// default coefficients; there is no clearing pass.
// A held output stalls the back end; the queue then fills and in_ready drops.
`default_nettype none

module mono_sum_biquad_crossover_unit (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_valid,
    output logic                                    in_ready,
    input  wire logic signed [msbc_pkg::SAMPLE_BITS-1:0] left_sample,
    input  wire logic signed [msbc_pkg::SAMPLE_BITS-1:0] right_sample,
    output logic                                    out_valid,
    input  wire                                     out_ready,
    output logic signed [msbc_pkg::SAMPLE_BITS-1:0] high_band,
    output logic signed [msbc_pkg::SAMPLE_BITS-1:0] low_band,
    input  wire                                     cfg_we,
    input  wire [msbc_pkg::REG_IDX_BITS-1:0]        cfg_index,
    input  wire [msbc_pkg::COEF_BITS-1:0]           cfg_data
);
    import msbc_pkg::*;

    coef_t    coef_reg;
    ff_item_t q_in, q_out;
    logic     q_push, q_pop, q_full, q_empty;

    // coefficient registers; a2 follows a0 in both bands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.hp.g0 <= RST_HP_GAIN_ZERO;
            coef_reg.hp.g1 <= RST_HP_GAIN_ONE;
            coef_reg.hp.f1 <= RST_HP_FB_ONE;
            coef_reg.hp.f2 <= RST_HP_FB_TWO;
            coef_reg.lp.g0 <= RST_LP_GAIN_ZERO;
            coef_reg.lp.g1 <= RST_LP_GAIN_ONE;
            coef_reg.lp.f1 <= RST_LP_FB_ONE;
            coef_reg.lp.f2 <= RST_LP_FB_TWO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HP_GAIN_ZERO: coef_reg.hp.g0 <= cfg_data;
                REG_HP_GAIN_ONE:  coef_reg.hp.g1 <= cfg_data;
                REG_HP_FB_ONE:    coef_reg.hp.f1 <= cfg_data;
                REG_HP_FB_TWO:    coef_reg.hp.f2 <= cfg_data;
                REG_LP_GAIN_ZERO: coef_reg.lp.g0 <= cfg_data;
                REG_LP_GAIN_ONE:  coef_reg.lp.g1 <= cfg_data;
                REG_LP_FB_ONE:    coef_reg.lp.f1 <= cfg_data;
                REG_LP_FB_TWO:    coef_reg.lp.f2 <= cfg_data;
                default:          coef_reg <= coef_reg;
            endcase
        end
    end

    // front: mono sum, input history, feedforward products
    msbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .coef         (coef_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    // short queue of feedforward sums between the two halves
    msbc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    // back: feedback recursion, output formatting, output register
    msbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_reg),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .high_band (high_band),
        .low_band  (low_band)
    );

endmodule

`default_nettype wire

>>> sv/msbc_front.sv
`default_nettype none

module msbc_front (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire logic signed [msbc_pkg::SAMPLE_BITS-1:0] left_sample,
    input  wire logic signed [msbc_pkg::SAMPLE_BITS-1:0] right_sample,
    input  wire msbc_pkg::coef_t                   coef,
    input  wire                                    q_full,
    output logic                                   q_push,
    output msbc_pkg::ff_item_t                     q_data
);
    import msbc_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mono;
    logic signed [SAMPLE_BITS-1:0] hist1_reg, hist2_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg, s1_x1_reg, s1_x2_reg;
    logic                          s1_valid_reg;
    logic                          accept;

    // halves floor, sum always fits the sample width
    assign mono = (left_sample >>> 1) + (right_sample >>> 1);

    assign q_push   = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || q_push;
    assign accept   = in_valid && in_ready;

    assign q_data.hp = ff_calc(coef.hp, s1_x_reg, s1_x1_reg, s1_x2_reg);
    assign q_data.lp = ff_calc(coef.lp, s1_x_reg, s1_x1_reg, s1_x2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hist1_reg    <= '0;
            hist2_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                hist1_reg    <= mono;
                hist2_reg    <= hist1_reg;
            end
            else if (q_push)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg  <= mono;
            s1_x1_reg <= hist1_reg;
            s1_x2_reg <= hist2_reg;
        end
    end

endmodule

`default_nettype wire

>>> sv/msbc_queue.sv
`default_nettype none

module msbc_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire msbc_pkg::ff_item_t din,
    output logic               full,
    input  wire                pop,
    output msbc_pkg::ff_item_t dout,
    output logic               empty
);
    import msbc_pkg::*;

    ff_item_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]     count_reg;

    assign full  = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_BITS + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

>>> sv/msbc_back.sv
`default_nettype none

module msbc_back (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire msbc_pkg::coef_t                   coef,
    input  wire                                    q_empty,
    input  wire msbc_pkg::ff_item_t                q_data,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output logic signed [msbc_pkg::SAMPLE_BITS-1:0] high_band,
    output logic signed [msbc_pkg::SAMPLE_BITS-1:0] low_band
);
    import msbc_pkg::*;

    logic                       busy_reg;
    logic                       out_valid_reg;
    logic signed [FB_BITS-1:0]  hp_y1_reg, hp_y2_reg, lp_y1_reg, lp_y2_reg;
    logic signed [ACC_BITS-1:0] hp_s_reg, lp_s_reg, hp_p_reg, lp_p_reg;
    logic signed [ACC_BITS-1:0] hp_s_next, lp_s_next, hp_p_next, lp_p_next;
    logic signed [ACC_BITS-1:0] hp_acc, lp_acc;
    logic signed [FB_BITS-1:0]  hp_y_next, lp_y_next;
    logic signed [SAMPLE_BITS-1:0] high_band_reg, low_band_reg;
    logic                       out_free;
    logic                       done;

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = !busy_reg && !q_empty;
    assign done     = busy_reg && out_free;

    // first step: feedforward minus f2*y2, and the low part of f1*y1
    assign hp_s_next = q_data.hp - fb_low(coef.hp.f2, hp_y2_reg) - fb_high(coef.hp.f2, hp_y2_reg);
    assign lp_s_next = q_data.lp - fb_low(coef.lp.f2, lp_y2_reg) - fb_high(coef.lp.f2, lp_y2_reg);
    assign hp_p_next = fb_low(coef.hp.f1, hp_y1_reg);
    assign lp_p_next = fb_low(coef.lp.f1, lp_y1_reg);

    // second step: close the loop with the high part of f1*y1
    assign hp_acc    = hp_s_reg - hp_p_reg - fb_high(coef.hp.f1, hp_y1_reg);
    assign lp_acc    = lp_s_reg - lp_p_reg - fb_high(coef.lp.f1, lp_y1_reg);
    assign hp_y_next = y_calc(hp_acc);
    assign lp_y_next = y_calc(lp_acc);

    assign out_valid = out_valid_reg;
    assign high_band = high_band_reg;
    assign low_band  = low_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            hp_y1_reg     <= '0;
            hp_y2_reg     <= '0;
            lp_y1_reg     <= '0;
            lp_y2_reg     <= '0;
        end
        else
        begin
            if (q_pop)
                busy_reg <= 1'b1;
            else if (done)
                busy_reg <= 1'b0;

            if (done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (done)
            begin
                hp_y1_reg <= hp_y_next;
                hp_y2_reg <= hp_y1_reg;
                lp_y1_reg <= lp_y_next;
                lp_y2_reg <= lp_y1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hp_s_reg <= hp_s_next;
            lp_s_reg <= lp_s_next;
            hp_p_reg <= hp_p_next;
            lp_p_reg <= lp_p_next;
        end
        if (done)
        begin
            high_band_reg <= out_fmt(hp_y_next);
            low_band_reg  <= out_fmt(lp_y_next);
        end
    end

    // a stalled result keeps the filter state frozen
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_free) |=> (busy_reg && $stable(hp_y1_reg) && $stable(lp_y1_reg)))
        else $error("filter state moved during output stall");

    // history shifts by exactly one on completion
    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (hp_y2_reg == $past(hp_y1_reg) && lp_y2_reg == $past(lp_y1_reg)))
        else $error("feedback history did not shift");

    // state only changes when an item finishes
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |=> ($stable(hp_y1_reg) && $stable(lp_y1_reg) && $stable(hp_y2_reg)))
        else $error("feedback state changed without a finished item");

endmodule

`default_nettype wire

>>> tb/mono_sum_biquad_crossover_unit_tb.sv
module mono_sum_biquad_crossover_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msbc_pkg::*;

    // no accept on either channel for this many cycles means a hang
    localparam int STALL_LIMIT  = 2000;
    // give the block some slack after the last result before reprogramming
    localparam int DRAIN_CYCLES = 12;
    localparam int BURST_ITEMS  = 32;

    // filter state clamps and output clamps
    localparam longint STATE_MAX = (longint'(1) <<< (FB_BITS - 1)) - 1;
    localparam longint STATE_MIN = -STATE_MAX - 1;
    localparam longint PCM_MAX   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint PCM_MIN   = -PCM_MAX - 1;

    localparam logic signed [SAMPLE_BITS-1:0] PCM_HI = SAMPLE_BITS'(PCM_MAX);
    localparam logic signed [SAMPLE_BITS-1:0] PCM_LO = SAMPLE_BITS'(PCM_MIN);

    localparam logic [COEF_BITS-1:0] COEF_HI = 32'h7FFF_FFFF;
    localparam logic [COEF_BITS-1:0] COEF_LO = 32'h8000_0000;

    typedef enum int {BAND_HIGH = 0, BAND_LOW = 1} band_e;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] high_val;
        logic signed [SAMPLE_BITS-1:0] low_val;
    } crossover_pair_t;

    // Predicts the crossover pair for every accepted frame and checks results in order.
    class crossover_scoreboard;
        coef_t             coefs;
        longint            mono_last;
        longint            mono_prior;
        longint            y_last [2];
        longint            y_prior [2];
        crossover_pair_t   expected_pairs [$];
        int unsigned       mismatches;

        function new();
            coefs.hp.g0 = RST_HP_GAIN_ZERO;
            coefs.hp.g1 = RST_HP_GAIN_ONE;
            coefs.hp.f1 = RST_HP_FB_ONE;
            coefs.hp.f2 = RST_HP_FB_TWO;
            coefs.lp.g0 = RST_LP_GAIN_ZERO;
            coefs.lp.g1 = RST_LP_GAIN_ONE;
            coefs.lp.f1 = RST_LP_FB_ONE;
            coefs.lp.f2 = RST_LP_FB_TWO;
            mono_last   = 0;
            mono_prior  = 0;
            y_last      = '{0, 0};
            y_prior     = '{0, 0};
            mismatches  = 0;
        endfunction

        function void set_coef(logic [REG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] value);
            case (idx)
                REG_HP_GAIN_ZERO: coefs.hp.g0 = value;
                REG_HP_GAIN_ONE:  coefs.hp.g1 = value;
                REG_HP_FB_ONE:    coefs.hp.f1 = value;
                REG_HP_FB_TWO:    coefs.hp.f2 = value;
                REG_LP_GAIN_ZERO: coefs.lp.g0 = value;
                REG_LP_GAIN_ONE:  coefs.lp.g1 = value;
                REG_LP_FB_ONE:    coefs.lp.f1 = value;
                REG_LP_FB_TWO:    coefs.lp.f2 = value;
                default: ;
            endcase
        endfunction

        // One DF-I step; the 64-bit sum wraps like a plain adder.
        function logic signed [SAMPLE_BITS-1:0] run_band(band_e b, band_coef_t c, longint x);
            longint g0, g1, f1, f2, acc, y, q;
            g0  = longint'(signed'(c.g0));
            g1  = longint'(signed'(c.g1));
            f1  = longint'(signed'(c.f1));
            f2  = longint'(signed'(c.f2));
            acc = g0 * (x <<< STATE_FRAC_BITS)
                + g1 * (mono_last <<< STATE_FRAC_BITS)
                + g0 * (mono_prior <<< STATE_FRAC_BITS)
                - f1 * y_last[b]
                - f2 * y_prior[b];
            y = acc >>> COEF_FRAC_BITS;
            if (y > STATE_MAX)
                y = STATE_MAX;
            else if (y < STATE_MIN)
                y = STATE_MIN;
            y_prior[b] = y_last[b];
            y_last[b]  = y;
            // drop the fraction toward zero
            q = (y < 0) ? -((-y) >>> STATE_FRAC_BITS) : (y >>> STATE_FRAC_BITS);
            if (q > PCM_MAX)
                q = PCM_MAX;
            else if (q < PCM_MIN)
                q = PCM_MIN;
            return q[SAMPLE_BITS-1:0];
        endfunction

        function void note_frame(logic signed [SAMPLE_BITS-1:0] l,
                                 logic signed [SAMPLE_BITS-1:0] r);
            longint          mono;
            crossover_pair_t p;
            // floor halving on each side, then sum
            mono       = longint'(l >>> 1) + longint'(r >>> 1);
            p.high_val = run_band(BAND_HIGH, coefs.hp, mono);
            p.low_val  = run_band(BAND_LOW, coefs.lp, mono);
            mono_prior = mono_last;
            mono_last  = mono;
            expected_pairs.push_back(p);
        endfunction

        function void check_pair(logic signed [SAMPLE_BITS-1:0] hb,
                                 logic signed [SAMPLE_BITS-1:0] lb);
            crossover_pair_t p;
            if (expected_pairs.size() == 0) begin
                $error("unexpected result: high_band %0d low_band %0d", hb, lb);
                mismatches++;
                return;
            end
            p = expected_pairs.pop_front();
            if (hb !== p.high_val) begin
                $error("high_band: expected %0d, got %0d", p.high_val, hb);
                mismatches++;
            end
            if (lb !== p.low_val) begin
                $error("low_band: expected %0d, got %0d", p.low_val, lb);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;

    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] left_sample  = '0;
    logic signed [SAMPLE_BITS-1:0] right_sample = '0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic signed [SAMPLE_BITS-1:0] high_band;
    logic signed [SAMPLE_BITS-1:0] low_band;
    logic                          cfg_we       = 1'b0;
    logic [REG_IDX_BITS-1:0]       cfg_index    = '0;
    logic [COEF_BITS-1:0]          cfg_data     = '0;

    crossover_scoreboard sb = new();

    // burst flags: while set, that side never idles
    bit          in_burst;
    bit          out_burst;
    int unsigned frames_sent;
    int unsigned pairs_taken;

    mono_sum_biquad_crossover_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .high_band    (high_band),
        .low_band     (low_band),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // single reset pulse at start of run
    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
    end

    // Called on a falling edge; returns on the falling edge after the accept.
    // Valid stays high into that edge so a back-to-back frame never drops it.
    task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
                              input logic signed [SAMPLE_BITS-1:0] r);
        int gap;
        if (frames_sent % BURST_ITEMS == 0)
            in_burst = ($urandom_range(0, 3) == 0);
        gap = in_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        left_sample  <= l;
        right_sample <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_frame(l, r);
        frames_sent++;
        @(negedge clk);
    endtask

    // drop valid, wait out every result, then let the back end go quiet
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // writes all eight registers on consecutive cycles; block must be idle
    task automatic program_coefs(input coef_t c);
        logic [COEF_BITS-1:0] word [NUM_REGS];
        word[REG_HP_GAIN_ZERO] = c.hp.g0;
        word[REG_HP_GAIN_ONE]  = c.hp.g1;
        word[REG_HP_FB_ONE]    = c.hp.f1;
        word[REG_HP_FB_TWO]    = c.hp.f2;
        word[REG_LP_GAIN_ZERO] = c.lp.g0;
        word[REG_LP_GAIN_ONE]  = c.lp.g1;
        word[REG_LP_FB_ONE]    = c.lp.f1;
        word[REG_LP_FB_TWO]    = c.lp.f2;
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_IDX_BITS'(i);
            cfg_data  <= word[i];
            sb.set_coef(REG_IDX_BITS'(i), word[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic band_coef_t make_band(logic [COEF_BITS-1:0] g0, logic [COEF_BITS-1:0] g1,
                                             logic [COEF_BITS-1:0] f1, logic [COEF_BITS-1:0] f2);
        band_coef_t b;
        b.g0 = g0;
        b.g1 = g1;
        b.f1 = f1;
        b.f2 = f2;
        return b;
    endfunction

    // mix of full-scale noise, quiet signal and rail values
    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
        int v;
        case ($urandom_range(0, 3))
            0, 1: v = $urandom();
            2:    v = $urandom_range(0, 4000) - 2000;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = int'(PCM_MAX);
                    1:       v = int'(PCM_MIN);
                    2:       v = -1;
                    default: v = 0;
                endcase
            end
        endcase
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_frame(draw_sample(), draw_sample());
    endtask

    // stimulus
    initial
    begin
        coef_t c;
        wait (rst_n === 1'b1);
        @(negedge clk);

        // directed frames on the default crossover
        send_frame('0, '0);
        send_frame(PCM_HI, PCM_HI);     // full-scale step up
        send_frame(PCM_HI, PCM_HI);
        send_frame(PCM_HI, PCM_HI);
        send_frame(PCM_LO, PCM_LO);     // full swing down, high band clips
        send_frame(PCM_LO, PCM_LO);
        send_frame(PCM_HI, PCM_LO);
        send_frame(PCM_LO, PCM_HI);
        send_frame(-24'sd1, -24'sd1);   // odd negatives floor to -1 each
        send_frame(24'sd1, 24'sd1);     // odd positives floor to zero
        send_frame(-24'sd1, 24'sd0);
        send_frame(-24'sd3, 24'sd3);
        send_frame(24'sh555555, 24'shAAAAAA);
        send_frame(24'shAAAAAA, 24'sh555555);
        send_frame(24'sd1000, -24'sd999);
        send_frame('0, '0);
        send_frame('0, '0);
        send_frame(PCM_LO, PCM_LO);
        send_frame('0, '0);
        send_frame('0, '0);

        send_noise(120);
        drain_pipeline();

        // max gains, most negative feedback: runaway, state clamps, sum wraps
        c.hp = make_band(COEF_HI, COEF_HI, COEF_LO, COEF_LO);
        c.lp = make_band(COEF_HI, COEF_HI, COEF_LO, COEF_LO);
        program_coefs(c);
        send_noise(30);
        drain_pipeline();

        c.hp = make_band(COEF_LO, COEF_LO, COEF_LO, COEF_LO);
        c.lp = make_band(COEF_LO, COEF_LO, COEF_LO, COEF_LO);
        program_coefs(c);
        send_noise(25);
        drain_pipeline();

        c.hp = make_band(COEF_HI, COEF_HI, COEF_HI, COEF_HI);
        c.lp = make_band(COEF_HI, COEF_HI, COEF_HI, COEF_HI);
        program_coefs(c);
        send_noise(20);
        drain_pipeline();

        // muted: outputs must go to zero whatever the history holds
        c = '0;
        program_coefs(c);
        send_noise(10);
        drain_pipeline();

        for (int k = 0; k < 4; k++) begin
            c.hp = make_band($urandom(), $urandom(), $urandom(), $urandom());
            c.lp = make_band($urandom(), $urandom(), $urandom(), $urandom());
            program_coefs(c);
            send_noise(45);
            drain_pipeline();
        end

        // back to the stock crossover with dirty history
        c.hp = make_band(RST_HP_GAIN_ZERO, RST_HP_GAIN_ONE, RST_HP_FB_ONE, RST_HP_FB_TWO);
        c.lp = make_band(RST_LP_GAIN_ZERO, RST_LP_GAIN_ONE, RST_LP_FB_ONE, RST_LP_FB_TWO);
        program_coefs(c);
        send_noise(50);

        drain_pipeline();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result side: random back-pressure, checks every accepted pair
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (pairs_taken % BURST_ITEMS == 0)
                out_burst = ($urandom_range(0, 3) == 0);
            gap = out_burst ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_pair(high_band, low_band);
            pairs_taken++;
            @(negedge clk);
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
